// File: src/vdb_pkg.sv
// vdb_pkg: shared constants, codes and control structs for the vectorscope binning block
// no dependencies; used by every other file of the block

package vdb_pkg;

	localparam int GRID_BITS_DEF  = 8;
	localparam int COUNT_BITS_DEF = 24;

	// port field widths
	localparam int KIND_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int BIN_W   = 8;
	localparam int CNT_W   = 24;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	// chroma sums in signed q.16, one unit of headroom above the full scale
	localparam int SUM_W   = 19;
	localparam int Q_SHIFT = 17;
	localparam logic signed [SUM_W-1:0] Q_ONE = 19'sd65536;

	// folded matrix, rotation and scale on the raw bytes
	localparam logic signed [SUM_W-1:0] CU_R = 19'sd172;
	localparam logic signed [SUM_W-1:0] CU_G = -19'sd250;
	localparam logic signed [SUM_W-1:0] CU_B = 19'sd78;
	localparam logic signed [SUM_W-1:0] CV_R = 19'sd209;
	localparam logic signed [SUM_W-1:0] CV_G = -19'sd34;
	localparam logic signed [SUM_W-1:0] CV_B = -19'sd175;

	function automatic logic signed [SUM_W-1:0] sx_byte(input logic [BYTE_W-1:0] b);
		return $signed({{(SUM_W-BYTE_W){1'b0}}, b});
	endfunction

	typedef struct packed {
		logic load;
		logic sum;
		logic bin;
		logic rd;
		logic commit;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic              clr_last;
		logic              out_free;
	} sts_t;

endpackage

// File: src/vdb_in_if.sv
// vdb_in_if: input channel carrying one item word per handshake
// depends on vdb_pkg for field widths

interface vdb_in_if;
	logic                         valid;
	logic                         ready;
	logic [vdb_pkg::KIND_W-1:0]   kind;
	logic [vdb_pkg::BYTE_W-1:0]   red;
	logic [vdb_pkg::BYTE_W-1:0]   green;
	logic [vdb_pkg::BYTE_W-1:0]   blue;
	logic [vdb_pkg::BYTE_W-1:0]   read_x;
	logic [vdb_pkg::BYTE_W-1:0]   read_y;

	modport source(output valid, kind, red, green, blue, read_x, read_y, input ready);
	modport sink(input valid, kind, red, green, blue, read_x, read_y, output ready);
endinterface

// File: src/vdb_out_if.sv
// vdb_out_if: result channel carrying one result word per handshake
// depends on vdb_pkg for field widths

interface vdb_out_if;
	logic                        valid;
	logic                        ready;
	logic [vdb_pkg::BIN_W-1:0]   bin_x;
	logic [vdb_pkg::BIN_W-1:0]   bin_y;
	logic [vdb_pkg::CNT_W-1:0]   count;
	logic [vdb_pkg::CNT_W-1:0]   peak;

	modport source(output valid, bin_x, bin_y, count, peak, input ready);
	modport sink(input valid, bin_x, bin_y, count, peak, output ready);
endinterface

// File: src/vectorscope_density_binning.sv
// vectorscope_density_binning: top level of the chroma density histogram
// depends on vdb_pkg, vdb_in_if, vdb_out_if, vdb_ctrl and vdb_datapath
//
//  channel   dir  word
//  items     in   kind, red, green, blue, read_x, read_y
//  results   out  bin_x, bin_y, count, peak
//
// pixel word: sums, bin map, memory read and update, from accept to next ready
// read word: bin map, memory read and update; unused kind: update only
// clear word: all 2^(2*GRID_BITS) memory rows, one memory row zeroed per cycle, then an update
// after reset a clearing pass zeroes every memory row before the first word is taken
// a finished result waits in the output register; only the commit stalls on results.ready

module vectorscope_density_binning #(
	parameter int GRID_BITS  = vdb_pkg::GRID_BITS_DEF,
	parameter int COUNT_BITS = vdb_pkg::COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	vdb_in_if.sink           items,
	vdb_out_if.source        results
);

	vdb_pkg::cmd_t cmd;
	vdb_pkg::sts_t sts;

	vdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_kind  (items.kind),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vdb_datapath #(
		.GRID_BITS  (GRID_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (items.kind),
		.red       (items.red),
		.green     (items.green),
		.blue      (items.blue),
		.read_x    (items.read_x),
		.read_y    (items.read_y),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.bin_x     (results.bin_x),
		.bin_y     (results.bin_y),
		.count     (results.count),
		.peak      (results.peak)
	);

endmodule

// File: src/vdb_datapath.sv
// vdb_datapath: chroma sums, bin mapping, histogram memory, peak and result register
// depends on vdb_pkg; driven by vdb_ctrl through cmd_t, reports through sts_t

module vdb_datapath #(
	parameter int GRID_BITS  = vdb_pkg::GRID_BITS_DEF,
	parameter int COUNT_BITS = vdb_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vdb_pkg::cmd_t                 cmd,
	output vdb_pkg::sts_t                 sts,
	input  logic [vdb_pkg::KIND_W-1:0]    kind,
	input  logic [vdb_pkg::BYTE_W-1:0]    red,
	input  logic [vdb_pkg::BYTE_W-1:0]    green,
	input  logic [vdb_pkg::BYTE_W-1:0]    blue,
	input  logic [vdb_pkg::BYTE_W-1:0]    read_x,
	input  logic [vdb_pkg::BYTE_W-1:0]    read_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [vdb_pkg::BIN_W-1:0]     bin_x,
	output logic [vdb_pkg::BIN_W-1:0]     bin_y,
	output logic [vdb_pkg::CNT_W-1:0]     count,
	output logic [vdb_pkg::CNT_W-1:0]     peak
);

	localparam int ADDR_W     = 2 * GRID_BITS;
	localparam int GRID_CELLS = 1 << ADDR_W;
	localparam int BIN_SHIFT  = vdb_pkg::Q_SHIFT - GRID_BITS;
	localparam int SUM_W      = vdb_pkg::SUM_W;
	localparam logic [GRID_BITS-1:0]  GRID_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

	logic [vdb_pkg::KIND_W-1:0] kind_q;
	logic [vdb_pkg::BYTE_W-1:0] red_q, green_q, blue_q, read_x_q, read_y_q;
	logic signed [SUM_W-1:0]    u_q, v_q;
	logic [GRID_BITS-1:0]       bx_q, by_q;
	logic [COUNT_BITS-1:0]      rd_q;
	logic [COUNT_BITS-1:0]      peak_q;
	logic [ADDR_W-1:0]          clr_addr_q;
	logic                       out_valid_q;
	logic [vdb_pkg::BIN_W-1:0]  bin_x_q, bin_y_q;
	logic [vdb_pkg::CNT_W-1:0]  count_q, peak_out_q;

	logic [COUNT_BITS-1:0] hist_mem [GRID_CELLS];

	logic signed [SUM_W-1:0] u_c, v_c;
	logic [COUNT_BITS-1:0]   cnt_inc, peak_nx, peak_rep, cnt_res;
	logic [GRID_BITS-1:0]    bx_res, by_res;
	logic                    is_pixel, is_read, wr_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic [COUNT_BITS-1:0]   wr_data;

	function automatic logic [GRID_BITS-1:0] to_bin(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] t;
		logic [SUM_W-1:0]        sh;
		t  = s + vdb_pkg::Q_ONE;
		sh = $unsigned(t) >> BIN_SHIFT;
		if (t < 0) begin
			return '0;
		end else if (sh > SUM_W'(GRID_MAX)) begin
			return GRID_MAX;
		end
		return sh[GRID_BITS-1:0];
	endfunction

	function automatic logic [GRID_BITS-1:0] clamp_rd(input logic [vdb_pkg::BYTE_W-1:0] c);
		if (32'(c) > 32'(GRID_MAX)) begin
			return GRID_MAX;
		end
		return GRID_BITS'(c);
	endfunction

	always_comb begin
		u_c = vdb_pkg::sx_byte(red_q) * vdb_pkg::CU_R
			+ vdb_pkg::sx_byte(green_q) * vdb_pkg::CU_G
			+ vdb_pkg::sx_byte(blue_q) * vdb_pkg::CU_B;
		v_c = vdb_pkg::sx_byte(red_q) * vdb_pkg::CV_R
			+ vdb_pkg::sx_byte(green_q) * vdb_pkg::CV_G
			+ vdb_pkg::sx_byte(blue_q) * vdb_pkg::CV_B;
	end

	assign is_pixel = (kind_q == vdb_pkg::KIND_PIXEL);
	assign is_read  = (kind_q == vdb_pkg::KIND_READ);
	assign cnt_inc  = (rd_q == CNT_MAX) ? rd_q : rd_q + CNT_ONE;
	assign peak_nx  = (is_pixel && cnt_inc > peak_q) ? cnt_inc : peak_q;
	assign peak_rep = (peak_nx > CNT_ONE) ? peak_nx : CNT_ONE;

	always_comb begin
		priority if (is_pixel) begin
			bx_res  = bx_q;
			by_res  = by_q;
			cnt_res = cnt_inc;
		end else if (is_read) begin
			bx_res  = bx_q;
			by_res  = by_q;
			cnt_res = rd_q;
		end else begin
			bx_res  = '0;
			by_res  = '0;
			cnt_res = '0;
		end
	end

	assign wr_en   = cmd.clr_step | (cmd.commit & is_pixel);
	assign wr_addr = cmd.clr_step ? clr_addr_q : {by_q, bx_q};
	assign wr_data = cmd.clr_step ? '0 : cnt_inc;

	// item payload and intermediate values
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			red_q    <= red;
			green_q  <= green;
			blue_q   <= blue;
			read_x_q <= read_x;
			read_y_q <= read_y;
		end
		if (cmd.sum) begin
			u_q <= u_c;
			v_q <= v_c;
		end
		if (cmd.bin) begin
			if (is_pixel) begin
				bx_q <= to_bin(u_q);
				by_q <= to_bin(v_q);
			end else begin
				bx_q <= clamp_rd(read_x_q);
				by_q <= clamp_rd(read_y_q);
			end
		end
		if (cmd.commit) begin
			bin_x_q    <= vdb_pkg::BIN_W'(bx_res);
			bin_y_q    <= vdb_pkg::BIN_W'(by_res);
			count_q    <= vdb_pkg::CNT_W'(cnt_res);
			peak_out_q <= vdb_pkg::CNT_W'(peak_rep);
		end
	end

	// histogram memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_q <= hist_mem[{by_q, bx_q}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				peak_q     <= '0;
			end else if (cmd.commit) begin
				peak_q <= peak_nx;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last = &clr_addr_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign bin_x     = bin_x_q;
	assign bin_y     = bin_y_q;
	assign count     = count_q;
	assign peak      = peak_out_q;

`ifndef SYNTHESIS
	a_write_not_below_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_pixel) |-> (wr_data >= rd_q))
		else $error("histogram write below read value");
	a_peak_covers_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_pixel) |=> (peak_q >= $past(cnt_inc)))
		else $error("peak below written count");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=>
		(out_valid_q && $stable(count_q) && $stable(peak_out_q)))
		else $error("pending result word changed before it was taken");
`endif

endmodule

// File: src/vdb_ctrl.sv
// vdb_ctrl: sequencer for clearing sweep, pixel update, bin read and result commit
// depends on vdb_pkg; drives vdb_datapath through cmd_t

module vdb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [vdb_pkg::KIND_W-1:0]  in_kind,
	output logic                        in_ready,
	input  vdb_pkg::sts_t               sts,
	output vdb_pkg::cmd_t               cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SWEEP,
		S_SUM,
		S_BIN,
		S_RD,
		S_UPD
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (in_kind)
						vdb_pkg::KIND_CLEAR: state_nx = S_SWEEP;
						vdb_pkg::KIND_PIXEL: state_nx = S_SUM;
						vdb_pkg::KIND_READ:  state_nx = S_BIN;
						default:             state_nx = S_UPD;
					endcase
				end
			end
			S_SWEEP: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nx = S_UPD;
				end
			end
			S_SUM: begin
				cmd.sum  = 1'b1;
				state_nx = S_BIN;
			end
			S_BIN: begin
				cmd.bin  = 1'b1;
				state_nx = S_RD;
			end
			S_RD: begin
				cmd.rd   = 1'b1;
				state_nx = S_UPD;
			end
			S_UPD: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

`ifndef SYNTHESIS
	a_commit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("result committed over a pending word");
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while busy");
	a_sweep_ends_in_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && sts.clr_last) |=> (state_q == S_UPD))
		else $error("clear sweep did not finish into commit");
	a_read_before_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> (state_q == S_UPD))
		else $error("memory read not followed by update");
`endif

endmodule

// File: tb/vectorscope_density_binning_tb.sv
// vectorscope_density_binning_tb: self-checking bench for the chroma density histogram
// drives item words and compares each result word against an internal bin-count predictor
// depends on vdb_pkg, vdb_in_if, vdb_out_if and vectorscope_density_binning
`timescale 1ns / 1ps

module vectorscope_density_binning_tb;

	localparam int GRID_BITS      = 8;
	localparam int GRID_SIDE      = 1 << GRID_BITS;
	localparam int BIN_SHIFT      = 17 - GRID_BITS;
	localparam int UNIT_Q16       = 65536;
	localparam int unsigned COUNT_MAX = (1 << vdb_pkg::CNT_W) - 1;

	localparam int COEF_UR = 172;
	localparam int COEF_UG = -250;
	localparam int COEF_UB = 78;
	localparam int COEF_VR = 209;
	localparam int COEF_VG = -34;
	localparam int COEF_VB = -175;

	localparam logic [vdb_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam int WATCHDOG_LIMIT = 400000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int RECENT_DEPTH   = 64;

	typedef struct packed {
		logic [vdb_pkg::BIN_W-1:0] bin_x;
		logic [vdb_pkg::BIN_W-1:0] bin_y;
		logic [vdb_pkg::CNT_W-1:0] count;
		logic [vdb_pkg::CNT_W-1:0] peak;
	} bin_result_t;

	logic clk = 1'b0;
	logic arst_n;

	vdb_in_if  items_ch ();
	vdb_out_if results_ch ();

	vectorscope_density_binning u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch)
	);

	always #6 clk = ~clk;

	int unsigned bin_counts[int unsigned];
	int unsigned peak_level;
	bin_result_t expected_results[$];
	bin_result_t last_result;
	bin_result_t got_result;
	logic [15:0] recent_bins[$];
	logic [23:0] palette[6];
	logic        no_idle = 1'b0;

	int error_count     = 0;
	int results_checked = 0;
	int pixel_words     = 0;
	int read_words      = 0;
	int clear_words     = 0;
	int unused_words    = 0;
	int unsigned top_peak = 0;
	int idle_cycles;

	function automatic logic [vdb_pkg::BYTE_W-1:0] rand_byte();
		return vdb_pkg::BYTE_W'($urandom);
	endfunction

	function automatic logic [vdb_pkg::BIN_W-1:0] chroma_bin(input int s);
		int t;
		t = UNIT_Q16 + s;
		if (t < 0)
			return '0;
		t = t >>> BIN_SHIFT;
		if (t > GRID_SIDE - 1)
			return vdb_pkg::BIN_W'(GRID_SIDE - 1);
		return vdb_pkg::BIN_W'(t);
	endfunction

	function automatic bin_result_t predict_bin_word(input logic [vdb_pkg::KIND_W-1:0] kind,
			input logic [vdb_pkg::BYTE_W-1:0] r, g, b, rx, ry);
		bin_result_t res;
		int u;
		int v;
		int unsigned key;
		int unsigned cnt;
		res = '0;
		case (kind)
			vdb_pkg::KIND_CLEAR: begin
				bin_counts.delete();
				peak_level = 0;
			end
			vdb_pkg::KIND_PIXEL: begin
				u = COEF_UR * int'(r) + COEF_UG * int'(g) + COEF_UB * int'(b);
				v = COEF_VR * int'(r) + COEF_VG * int'(g) + COEF_VB * int'(b);
				res.bin_x = chroma_bin(u);
				res.bin_y = chroma_bin(v);
				key = 32'({res.bin_y, res.bin_x});
				cnt = bin_counts.exists(key) ? bin_counts[key] : 0;
				if (cnt < COUNT_MAX)
					cnt++;
				bin_counts[key] = cnt;
				res.count = cnt[vdb_pkg::CNT_W-1:0];
				if (cnt > peak_level)
					peak_level = cnt;
			end
			vdb_pkg::KIND_READ: begin
				res.bin_x = rx;
				res.bin_y = ry;
				key = 32'({res.bin_y, res.bin_x});
				cnt = bin_counts.exists(key) ? bin_counts[key] : 0;
				res.count = cnt[vdb_pkg::CNT_W-1:0];
			end
			default: ;
		endcase
		res.peak = (peak_level > 1) ? peak_level[vdb_pkg::CNT_W-1:0] : vdb_pkg::CNT_W'(1);
		return res;
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got, want);
		error_count++;
		$display("ERROR result %0d: %s is %0d, expected %0d", results_checked, field, got, want);
	endtask

	task automatic send_word(input logic [vdb_pkg::KIND_W-1:0] kind,
			input logic [vdb_pkg::BYTE_W-1:0] r, g, b, rx, ry);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(99) < 34)
			gap = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 3);
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid  <= 1'b1;
		items_ch.kind   <= kind;
		items_ch.red    <= r;
		items_ch.green  <= g;
		items_ch.blue   <= b;
		items_ch.read_x <= rx;
		items_ch.read_y <= ry;
		do @(posedge clk); while (items_ch.ready !== 1'b1);
		last_result = predict_bin_word(kind, r, g, b, rx, ry);
		expected_results.push_back(last_result);
		if (32'(last_result.peak) > top_peak)
			top_peak = 32'(last_result.peak);
		case (kind)
			vdb_pkg::KIND_CLEAR: clear_words++;
			vdb_pkg::KIND_PIXEL: pixel_words++;
			vdb_pkg::KIND_READ:  read_words++;
			default:             unused_words++;
		endcase
	endtask

	task automatic send_pixel(input logic [vdb_pkg::BYTE_W-1:0] r, g, b);
		send_word(vdb_pkg::KIND_PIXEL, r, g, b, rand_byte(), rand_byte());
		recent_bins.push_back({last_result.bin_y, last_result.bin_x});
		if (recent_bins.size() > RECENT_DEPTH)
			void'(recent_bins.pop_front());
	endtask

	task automatic send_read(input logic [vdb_pkg::BYTE_W-1:0] rx, ry);
		send_word(vdb_pkg::KIND_READ, rand_byte(), rand_byte(), rand_byte(), rx, ry);
	endtask

	task automatic send_random_word();
		int pick;
		logic [23:0] color;
		logic [15:0] spot;
		pick = $urandom_range(99);
		if (pick < 35) begin
			color = palette[$urandom_range(5)];
			send_pixel({color[23:18], 2'($urandom)}, {color[15:10], 2'($urandom)},
				{color[7:2], 2'($urandom)});
		end else if (pick < 60) begin
			send_pixel(rand_byte(), rand_byte(), rand_byte());
		end else if (pick < 85 && recent_bins.size() > 0) begin
			spot = recent_bins[$urandom_range(recent_bins.size() - 1)];
			send_read(spot[7:0], spot[15:8]);
		end else if (pick < 94) begin
			send_read(rand_byte(), rand_byte());
		end else begin
			send_word(KIND_UNUSED, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
				rand_byte());
		end
	endtask

	task automatic test_empty_grid();
		send_read(8'd0, 8'd0);
		send_read(8'd255, 8'd255);
		send_read(8'd0, 8'd255);
		send_read(8'd255, 8'd0);
		send_word(KIND_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
	endtask

	task automatic test_pixel_extremes();
		logic [15:0] red_spot;
		logic [15:0] green_spot;
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		red_spot = {last_result.bin_y, last_result.bin_x};
		send_pixel(8'd0, 8'd255, 8'd0);
		green_spot = {last_result.bin_y, last_result.bin_x};
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		repeat (4) send_pixel(8'd255, 8'd0, 8'd0);
		send_read(8'd128, 8'd128);
		send_read(red_spot[7:0], red_spot[15:8]);
		send_read(green_spot[7:0], green_spot[15:8]);
		send_word(KIND_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_clear();
		send_word(vdb_pkg::KIND_CLEAR, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
			rand_byte());
		send_read(8'd128, 8'd128);
		send_pixel(8'd64, 8'd64, 8'd64);
	endtask

	task automatic test_random_mix(input int n_words);
		int clear_a;
		int clear_b;
		clear_a = $urandom_range(100, 380);
		clear_b = $urandom_range(420, n_words - 100);
		foreach (palette[i])
			palette[i] = 24'($urandom);
		for (int i = 0; i < n_words; i++) begin
			if (i == clear_a || i == clear_b)
				send_word(vdb_pkg::KIND_CLEAR, rand_byte(), rand_byte(), rand_byte(),
					rand_byte(), rand_byte());
			else
				send_random_word();
		end
	endtask

	task automatic test_streaming(input int n_words);
		no_idle = 1'b1;
		for (int i = 0; i < n_words; i++)
			send_random_word();
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, pending", 0, 0);
			end else begin
				got_result = expected_results.pop_front();
				if (results_ch.bin_x !== got_result.bin_x)
					report_mismatch("bin_x", 32'(results_ch.bin_x), 32'(got_result.bin_x));
				if (results_ch.bin_y !== got_result.bin_y)
					report_mismatch("bin_y", 32'(results_ch.bin_y), 32'(got_result.bin_y));
				if (results_ch.count !== got_result.count)
					report_mismatch("count", 32'(results_ch.count), 32'(got_result.count));
				if (results_ch.peak !== got_result.peak)
					report_mismatch("peak", 32'(results_ch.peak), 32'(got_result.peak));
			end
			results_checked++;
		end
	end

	initial begin
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			results_ch.ready <= no_idle || ($urandom_range(99) >= 34);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((items_ch.valid === 1'b1 && items_ch.ready === 1'b1) ||
					(results_ch.valid === 1'b1 && results_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n          <= 1'b0;
		items_ch.valid  <= 1'b0;
		items_ch.kind   <= vdb_pkg::KIND_CLEAR;
		items_ch.red    <= '0;
		items_ch.green  <= '0;
		items_ch.blue   <= '0;
		items_ch.read_x <= '0;
		items_ch.read_y <= '0;
		peak_level = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_grid();
		test_pixel_extremes();
		test_clear();
		test_random_mix(780);
		test_streaming(150);

		items_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pixel, %0d read, %0d clear and %0d unused-kind words",
			pixel_words, read_words, clear_words, unused_words);
		$display("checked %0d results, highest peak seen %0d, %0d mismatches",
			results_checked, top_peak, error_count);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
